### rtl/ttcv_pkg.sv
// Shared constants, register indexes and controller command type for the cursor tracker.
package ttcv_pkg;

   localparam int POS_FRAC_BITS_DEF = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam int QUOT_W = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_SPAN = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_SPAN = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_WEIGHT = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_LIMIT = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_START = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEN_THRESHOLD = 4'd7;

   localparam logic [10:0] DEAD_ZONE_RST = 11'd48;
   localparam logic [11:0] LEFT_SPAN_RST = 12'd1280;
   localparam logic [10:0] RIGHT_SPAN_RST = 11'd800;
   localparam logic [13:0] MAX_SPEED_RST = 14'd3072;
   localparam logic [8:0] SMOOTH_WEIGHT_RST = 9'd205;
   localparam logic [8:0] SMOOTH_WEIGHT_MAX = 9'd256;
   localparam logic [11:0] X_LIMIT_RST = 12'd999;
   localparam logic [11:0] X_START_RST = 12'd500;
   localparam logic [7:0] PEN_THRESHOLD_RST = 8'd128;

   typedef struct packed {
      logic load_in;
      logic mul;
      logic div_step;
      logic raw;
      logic mac_old;
      logic mac_new;
      logic vel;
      logic move;
      logic load_out;
   } cmd_type;

endpackage

### rtl/ttcv_ctrl.sv
// Controller state machine sequencing one item through the tracker datapath.
module ttcv_ctrl import ttcv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MUL  = 9'b000000010,
      ST_DIV  = 9'b000000100,
      ST_RAW  = 9'b000001000,
      ST_MAC1 = 9'b000010000,
      ST_MAC2 = 9'b000100000,
      ST_VEL  = 9'b001000000,
      ST_MOVE = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   localparam int CNT_W = $clog2(QUOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            cmd.raw = 1'b1;
            state_in = ST_MAC1;
         end
         ST_MAC1: begin
            cmd.mac_old = 1'b1;
            state_in = ST_MAC2;
         end
         ST_MAC2: begin
            cmd.mac_new = 1'b1;
            state_in = ST_VEL;
         end
         ST_VEL: begin
            cmd.vel = 1'b1;
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/ttcv_datapath.sv
// Datapath: registers, speed divider, moving average, position update and result registers.
module ttcv_datapath import ttcv_pkg::*; #(
   parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic signed [11:0]     req_angle_sample,
   input  logic [7:0]             req_hand_level,
   output logic [11:0]            rsp_prev_x,
   output logic [11:0]            rsp_new_x,
   output logic signed [14:0]     rsp_smoothed_speed,
   output logic                   rsp_pen_down
);

   localparam int PW = 12 + POS_FRAC_BITS;
   localparam int SW = PW + 2;
   localparam int SH_UP = (POS_FRAC_BITS >= 8) ? POS_FRAC_BITS - 8 : 0;
   localparam int SH_DN = (POS_FRAC_BITS >= 8) ? 0 : 8 - POS_FRAC_BITS;
   localparam int PROD_W = 12 + QUOT_W;

   logic [10:0] dead_zone_ff;
   logic [11:0] left_span_ff;
   logic [10:0] right_span_ff;
   logic [13:0] max_speed_ff;
   logic [8:0] weight_ff;
   logic [11:0] x_limit_ff;
   logic [7:0] pen_thr_ff;

   logic [11:0] mag_ff, mag_in;
   logic neg_ff;
   logic [11:0] span_ff, span_in;
   logic zone_ff, full_ff, pen_ff;
   logic [11:0] rem_ff;
   logic [QUOT_W-1:0] quo_ff;
   logic signed [14:0] raw_ff;
   logic signed [25:0] acc_ff;
   logic signed [15:0] vel_ff, vel_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [11:0] prev_pix_ff;

   logic [11:0] prev_x_ff, new_x_ff;
   logic signed [14:0] speed_ff;
   logic pen_out_ff;

   logic [PROD_W-1:0] prod;
   logic [12:0] trial, diff;
   logic ge;
   logic [13:0] mag_sel;
   logic [8:0] weight_sel;
   logic [8:0] new_weight;
   logic signed [25:0] acc_rnd;
   logic signed [SW-1:0] v_ext, bias, step, pos_sum, lim_ext;

   assign mag_in = req_angle_sample[11] ? 12'(-req_angle_sample) : req_angle_sample;
   assign span_in = req_angle_sample[11] ? left_span_ff : {1'b0, right_span_ff};

   assign prod = mag_ff * max_speed_ff;
   assign trial = {rem_ff, quo_ff[QUOT_W-1]};
   assign diff = trial - {1'b0, span_ff};
   assign ge = (trial >= {1'b0, span_ff});

   assign mag_sel = zone_ff ? 14'd0 : (full_ff ? max_speed_ff : quo_ff);
   assign new_weight = SMOOTH_WEIGHT_MAX - weight_ff;
   assign weight_sel = (csr_data[8:0] > SMOOTH_WEIGHT_MAX) ? SMOOTH_WEIGHT_MAX : csr_data[8:0];

   assign acc_rnd = acc_ff + (acc_ff[25] ? 26'sd255 : 26'sd0);
   assign vel_in = acc_rnd[23:8];

   always_comb begin
      v_ext = SW'(vel_ff);
      bias = vel_ff[15] ? SW'((1 << SH_DN) - 1) : '0;
      step = ((v_ext + bias) >>> SH_DN) <<< SH_UP;
      pos_sum = signed'({2'b00, pos_ff}) + step;
      lim_ext = signed'({2'b00, x_limit_ff, {POS_FRAC_BITS{1'b0}}});
      if (pos_sum[SW-1]) begin
         pos_in = '0;
      end else if (pos_sum > lim_ext) begin
         pos_in = lim_ext[PW-1:0];
      end else begin
         pos_in = pos_sum[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RST;
         left_span_ff <= LEFT_SPAN_RST;
         right_span_ff <= RIGHT_SPAN_RST;
         max_speed_ff <= MAX_SPEED_RST;
         weight_ff <= SMOOTH_WEIGHT_RST;
         x_limit_ff <= X_LIMIT_RST;
         pen_thr_ff <= PEN_THRESHOLD_RST;
         vel_ff <= '0;
         pos_ff <= {X_START_RST, {POS_FRAC_BITS{1'b0}}};
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DEAD_ZONE: dead_zone_ff <= csr_data[10:0];
               CSR_LEFT_SPAN: left_span_ff <= csr_data[11:0];
               CSR_RIGHT_SPAN: right_span_ff <= csr_data[10:0];
               CSR_MAX_SPEED: max_speed_ff <= csr_data[13:0];
               CSR_SMOOTH_WEIGHT: weight_ff <= weight_sel;
               CSR_X_LIMIT: x_limit_ff <= csr_data[11:0];
               CSR_X_START: pos_ff <= {csr_data[11:0], {POS_FRAC_BITS{1'b0}}};
               CSR_PEN_THRESHOLD: pen_thr_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         if (cmd.vel) begin
            vel_ff <= vel_in;
         end
         if (cmd.move) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         mag_ff <= mag_in;
         neg_ff <= req_angle_sample[11];
         span_ff <= span_in;
         zone_ff <= ({1'b0, dead_zone_ff} > mag_in);
         full_ff <= (mag_in >= span_in);
         pen_ff <= (req_hand_level > pen_thr_ff);
      end
      if (cmd.mul) begin
         rem_ff <= prod[PROD_W-1:QUOT_W];
         quo_ff <= prod[QUOT_W-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? diff[11:0] : trial[11:0];
         quo_ff <= {quo_ff[QUOT_W-2:0], ge};
      end
      if (cmd.raw) begin
         raw_ff <= neg_ff ? -signed'({1'b0, mag_sel}) : signed'({1'b0, mag_sel});
      end
      if (cmd.mac_old) begin
         acc_ff <= signed'({1'b0, weight_ff}) * vel_ff;
      end
      if (cmd.mac_new) begin
         acc_ff <= acc_ff + 26'(signed'({1'b0, new_weight}) * raw_ff);
      end
      if (cmd.move) begin
         prev_pix_ff <= pos_ff[PW-1 -: 12];
      end
      if (cmd.load_out) begin
         prev_x_ff <= prev_pix_ff;
         new_x_ff <= pos_ff[PW-1 -: 12];
         speed_ff <= vel_ff[14:0];
         pen_out_ff <= pen_ff;
      end
   end

   assign rsp_prev_x = prev_x_ff;
   assign rsp_new_x = new_x_ff;
   assign rsp_smoothed_speed = speed_ff;
   assign rsp_pen_down = pen_out_ff;

endmodule

### rtl/tilt_to_cursor_velocity_tracker_core.sv
// Top level of the tilt-to-cursor velocity tracker.
// Each item (wrist angle, hand level) yields one result: previous and new cursor x, smoothed
// speed and pen-down flag. An item runs from acceptance to result valid through the multiply,
// the 14 one-bit steps of the shared restoring divider, and the average and move steps;
// one item is in flight at a time, and the next item is taken once the result is registered,
// which waits while the previous result is stalled at the output. Configuration writes are
// taken every cycle outside reset; writing x_start reloads the cursor position at once.
module tilt_to_cursor_velocity_tracker_core import ttcv_pkg::*; #(
   parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [11:0]     req_angle_sample,
   input  logic [7:0]             req_hand_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [11:0]            rsp_prev_x,
   output logic [11:0]            rsp_new_x,
   output logic signed [14:0]     rsp_smoothed_speed,
   output logic                   rsp_pen_down,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type cmd;

   assign csr_ready = !reset;

   ttcv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ttcv_datapath #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_angle_sample   (req_angle_sample),
      .req_hand_level     (req_hand_level),
      .rsp_prev_x         (rsp_prev_x),
      .rsp_new_x          (rsp_new_x),
      .rsp_smoothed_speed (rsp_smoothed_speed),
      .rsp_pen_down       (rsp_pen_down)
   );

endmodule

### sim/tb_tilt_to_cursor_velocity_tracker_core.sv
// Self-checking testbench for the tilt-to-cursor velocity tracker: directed edges, then random items.
module tb_tilt_to_cursor_velocity_tracker_core import ttcv_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_FB = POS_FRAC_BITS_DEF;
   localparam int SETTLE_CYCLES = 30;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 300;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO = 4'd8;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI = 4'd15;
   localparam logic [CSR_INDEX_W-1:0] REG_ORDER [8] = '{CSR_DEAD_ZONE, CSR_LEFT_SPAN,
      CSR_RIGHT_SPAN, CSR_MAX_SPEED, CSR_SMOOTH_WEIGHT, CSR_X_LIMIT, CSR_X_START,
      CSR_PEN_THRESHOLD};
   localparam int REG_LO [8] = '{0, 1, 1, 0, 0, 0, 0, 0};
   localparam int REG_HI [8] = '{2047, 2048, 2047, 16383, 256, 4095, 4095, 255};
   localparam int REG_WIDTH [8] = '{11, 12, 11, 14, 9, 12, 12, 8};

   typedef struct packed {
      logic [11:0]        prev_x;
      logic [11:0]        new_x;
      logic signed [14:0] speed;
      logic               pen;
   } cursor_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [11:0]     req_angle_sample = '0;
   logic [7:0]             req_hand_level = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [11:0]            rsp_prev_x;
   logic [11:0]            rsp_new_x;
   logic signed [14:0]     rsp_smoothed_speed;
   logic                   rsp_pen_down;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [10:0] dead_zone_m;
   logic [11:0] left_span_m;
   logic [10:0] right_span_m;
   logic [13:0] max_speed_m;
   logic [8:0]  weight_m;
   logic [11:0] x_limit_m;
   logic [7:0]  pen_thr_m;
   int          velocity_m;
   int          xpos_m;

   cursor_result_type expected_cursor_q[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int src_idle_pct = 0;
   int snk_stall_pct = 0;

   tilt_to_cursor_velocity_tracker_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_angle_sample   (req_angle_sample),
      .req_hand_level     (req_hand_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_prev_x         (rsp_prev_x),
      .rsp_new_x          (rsp_new_x),
      .rsp_smoothed_speed (rsp_smoothed_speed),
      .rsp_pen_down       (rsp_pen_down),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic reset_model();
      dead_zone_m = DEAD_ZONE_RST;
      left_span_m = LEFT_SPAN_RST;
      right_span_m = RIGHT_SPAN_RST;
      max_speed_m = MAX_SPEED_RST;
      weight_m = SMOOTH_WEIGHT_RST;
      x_limit_m = X_LIMIT_RST;
      pen_thr_m = PEN_THRESHOLD_RST;
      velocity_m = 0;
      xpos_m = int'(X_START_RST) << POS_FB;
   endtask

   task automatic apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_DEAD_ZONE: dead_zone_m = data[10:0];
         CSR_LEFT_SPAN: left_span_m = data[11:0];
         CSR_RIGHT_SPAN: right_span_m = data[10:0];
         CSR_MAX_SPEED: max_speed_m = data[13:0];
         CSR_SMOOTH_WEIGHT: begin
            weight_m = (data[8:0] > SMOOTH_WEIGHT_MAX) ? SMOOTH_WEIGHT_MAX : data[8:0];
         end
         CSR_X_LIMIT: x_limit_m = data[11:0];
         CSR_X_START: begin
            xpos_m = int'(data[11:0]) << POS_FB;
         end
         CSR_PEN_THRESHOLD: pen_thr_m = data[7:0];
         default: ;
      endcase
   endtask

   function automatic cursor_result_type predict_frame(input logic signed [11:0] ang,
                                                       input logic [7:0] lvl);
      int mag, span, spd, raw, v, step, prev, pos, lim;
      cursor_result_type r;
      mag = (ang < 0) ? -int'(ang) : int'(ang);
      span = (ang < 0) ? int'(left_span_m) : int'(right_span_m);
      if (mag < int'(dead_zone_m)) begin
         raw = 0;
      end else begin
         if (mag >= span) begin
            spd = int'(max_speed_m);
         end else begin
            spd = (mag * int'(max_speed_m)) / span;
         end
         raw = (ang < 0) ? -spd : spd;
      end
      v = (int'(weight_m) * velocity_m + (256 - int'(weight_m)) * raw) / 256;
      velocity_m = v;
      if (POS_FB >= 8) begin
         step = v <<< (POS_FB - 8);
      end else begin
         step = v / (1 << (8 - POS_FB));
      end
      prev = xpos_m;
      pos = prev + step;
      lim = int'(x_limit_m) << POS_FB;
      if (pos < 0) pos = 0;
      if (pos > lim) pos = lim;
      xpos_m = pos;
      r.prev_x = 12'(prev >> POS_FB);
      r.new_x = 12'(pos >> POS_FB);
      r.speed = 15'(v);
      r.pen = (lvl > pen_thr_m);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) note_mismatch(what, want, got);
   endtask

   task automatic send_frame(input logic signed [11:0] ang, input logic [7:0] lvl);
      cursor_result_type want;
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_angle_sample <= ang;
      req_hand_level <= lvl;
      do @(posedge clock); while (req_stall);
      want = predict_frame(ang, lvl);
      expected_cursor_q = {expected_cursor_q, want};
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cursor_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [11:0] pick_angle();
      int mag, lim;
      logic neg;
      neg = 1'($urandom_range(1));
      lim = neg ? 2048 : 2047;
      case ($urandom_range(3))
         0: return 12'($urandom);
         1: mag = int'(dead_zone_m) + $urandom_range(4) - 2;
         2: mag = (neg ? int'(left_span_m) : int'(right_span_m)) + $urandom_range(4) - 2;
         default: mag = $urandom_range(lim);
      endcase
      if (mag < 0) mag = 0;
      if (mag > lim) mag = lim;
      return neg ? 12'(-mag) : 12'(mag);
   endfunction

   task automatic randomize_config();
      int val;
      logic [CSR_DATA_W-1:0] data;
      for (int k = 0; k < 8; k++) begin
         case ($urandom_range(3))
            0: val = REG_LO[k];
            1: val = REG_HI[k];
            default: val = $urandom_range(REG_HI[k], REG_LO[k]);
         endcase
         if (REG_ORDER[k] == CSR_SMOOTH_WEIGHT && $urandom_range(7) == 0) begin
            val = $urandom_range(511, 257);
         end
         data = 16'(val);
         if ($urandom_range(1)) data = data | (16'($urandom) << REG_WIDTH[k]);
         csr_write(REG_ORDER[k], data);
      end
   endtask

   task automatic test_default_span_edges();
      send_frame(12'sd0, 8'd0);
      send_frame(12'sd47, 8'd128);
      send_frame(-12'sd47, 8'd129);
      send_frame(12'sd48, 8'd255);
      send_frame(-12'sd48, 8'd1);
      send_frame(12'sd799, 8'd200);
      send_frame(12'sd800, 8'd127);
      send_frame(12'sd2047, 8'd255);
      send_frame(-12'sd1279, 8'd0);
      send_frame(-12'sd1280, 8'd170);
      send_frame(-12'sd2048, 8'd85);
      send_frame(12'sd1, 8'd128);
   endtask

   task automatic test_register_extremes();
      wait_for_results();
      csr_write(CSR_DEAD_ZONE, 16'd0);
      csr_write(CSR_LEFT_SPAN, 16'd2048);
      csr_write(CSR_RIGHT_SPAN, 16'd2047);
      csr_write(CSR_MAX_SPEED, 16'd16383);
      csr_write(CSR_SMOOTH_WEIGHT, 16'd0);
      csr_write(CSR_PEN_THRESHOLD, 16'd0);
      send_frame(-12'sd2048, 8'd1);
      send_frame(12'sd2047, 8'd255);
      send_frame(-12'sd1, 8'd0);
      send_frame(12'sd1, 8'd128);
      wait_for_results();
      csr_write(CSR_SMOOTH_WEIGHT, 16'hFF2C);
      csr_write(CSR_X_LIMIT, 16'd4095);
      send_frame(12'sd2047, 8'd0);
      send_frame(-12'sd2048, 8'd255);
      wait_for_results();
      csr_write(CSR_LEFT_SPAN, 16'hF000);
      csr_write(CSR_RIGHT_SPAN, 16'hF800);
      csr_write(CSR_DEAD_ZONE, 16'd5);
      csr_write(CSR_SMOOTH_WEIGHT, 16'd128);
      send_frame(12'sd6, 8'd10);
      send_frame(-12'sd6, 8'd20);
      send_frame(12'sd4, 8'd30);
      wait_for_results();
      csr_write(CSR_X_LIMIT, 16'd100);
      csr_write(CSR_X_START, 16'd4095);
      send_frame(12'sd0, 8'd40);
      send_frame(12'sd0, 8'd50);
      wait_for_results();
      csr_write(CSR_X_LIMIT, 16'd0);
      send_frame(12'sd2047, 8'd60);
      wait_for_results();
      csr_write(CSR_UNUSED_LO, 16'hFFFF);
      csr_write(CSR_UNUSED_HI, 16'h0000);
      csr_write(CSR_PEN_THRESHOLD, 16'd255);
      csr_write(CSR_X_LIMIT, 16'hF0FF);
      csr_write(CSR_X_START, 16'h0000);
      send_frame(-12'sd2048, 8'd255);
      send_frame(12'sd2047, 8'd255);
   endtask

   task automatic test_random_traffic();
      int src_pct [4] = '{0, 61, 0, 29};
      int snk_pct [4] = '{0, 0, 61, 29};
      for (int p = 0; p < 4; p++) begin
         wait_for_results();
         randomize_config();
         src_idle_pct = src_pct[p];
         snk_stall_pct = snk_pct[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == PHASE_ITEMS / 2) wait_for_results();
            send_frame(pick_angle(), 8'($urandom));
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < snk_stall_pct);
   end

   always @(posedge clock) begin : check_results
      cursor_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cursor_q.size() == 0) begin
            note_mismatch("unexpected result, prev_x", 0, int'(rsp_prev_x));
         end else begin
            want = expected_cursor_q.pop_front();
            check_field("prev_x", int'(want.prev_x), int'(rsp_prev_x));
            check_field("new_x", int'(want.new_x), int'(rsp_new_x));
            check_field("smoothed_speed", int'(want.speed), int'(rsp_smoothed_speed));
            check_field("pen_down", int'(want.pen), int'(rsp_pen_down));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_span_edges();
      test_register_extremes();
      test_random_traffic();
      wait_for_results();
      if (mismatch_count == 0 && expected_cursor_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
rtl/ttcv_pkg.sv
rtl/ttcv_ctrl.sv
rtl/ttcv_datapath.sv
rtl/tilt_to_cursor_velocity_tracker_core.sv
sim/tb_tilt_to_cursor_velocity_tracker_core.sv
